>>> hw/rtl/cat_pkg.sv
// cat_pkg: shared types and constants for the connection aging table.
// Used by cat_cell and connection_aging_table; no dependencies.

package cat_pkg;

    // Field widths fixed by the command and result formats
    localparam int CMD_ID_W        = 32;
    localparam int AGE_W           = 16;
    localparam int TIMEOUT_W       = 16;

    localparam logic [AGE_W-1:0]     AGE_MAX       = '1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(60);

    // Parameter defaults
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 32;

    // Command codes; code 3 is a no-op
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_TICK   = 2'd2
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Input beat
    typedef struct packed {
        t_func                func;
        logic [CMD_ID_W-1:0]  connection_id;
    } t_cmd;

    // Output beat
    typedef struct packed {
        t_status              status;
        logic                 evicted_valid;
        logic [CMD_ID_W-1:0]  evicted_id;
        logic                 last;
    } t_result;

    // Per-cell operation driven by the controller
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_WRITE = 2'd1,
        CELL_SHIFT = 2'd2,
        CELL_AGE   = 2'd3
    } t_cell_op;

    // Cell status that moves down the chain along with the id
    typedef struct packed {
        logic              valid;
        logic              expire;
        logic [AGE_W-1:0]  age;
    } t_cell_meta;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_EVICT = 2'd2
    } t_state;

endpackage

>>> hw/rtl/cat_cell.sv
// cat_cell: one slot of the aging table, holding an id, its age and an expire flag.
// Depends on cat_pkg; instantiated in a row by connection_aging_table.

module cat_cell
    import cat_pkg::*;
#(
    parameter int ID_WIDTH = DEF_ID_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_op              i_op,
    input  logic [TIMEOUT_W-1:0]  i_timeout,
    input  logic [ID_WIDTH-1:0]   i_key,
    input  t_cell_meta            i_nbr_meta,
    input  logic [ID_WIDTH-1:0]   i_nbr_id,
    output t_cell_meta            o_meta,
    output logic [ID_WIDTH-1:0]   o_id,
    output logic                  o_match
);

    t_cell_meta           r_meta, n_meta;
    logic [ID_WIDTH-1:0]  r_id, n_id;
    logic [AGE_W:0]       age_inc;
    logic [AGE_W-1:0]     age_sat;

    // Saturating age increment
    assign age_inc = {1'b0, r_meta.age} + (AGE_W+1)'(1);
    assign age_sat = (r_meta.age == AGE_MAX) ? AGE_MAX : age_inc[AGE_W-1:0];

    // Next slot contents
    always_comb begin
        n_meta = r_meta;
        n_id   = r_id;
        unique case (i_op)
            CELL_HOLD: begin
            end
            CELL_WRITE: begin
                n_meta.valid  = 1'b1;
                n_meta.expire = 1'b0;
                n_meta.age    = '0;
                n_id          = i_key;
            end
            CELL_SHIFT: begin
                n_meta = i_nbr_meta;
                n_id   = i_nbr_id;
            end
            CELL_AGE: begin
                if (r_meta.valid) begin
                    n_meta.age    = age_sat;
                    n_meta.expire = (age_sat > i_timeout);
                end
            end
            default: begin
            end
        endcase
    end

    // Occupancy flags under reset; age and id are payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid  <= 1'b0;
            r_meta.expire <= 1'b0;
        end else begin
            r_meta.valid  <= n_meta.valid;
            r_meta.expire <= n_meta.expire;
        end
        r_meta.age <= n_meta.age;
        r_id       <= n_id;
    end

    assign o_meta  = r_meta;
    assign o_id    = r_id;
    assign o_match = r_meta.valid && (r_id == i_key);

endmodule

>>> hw/rtl/connection_aging_table.sv
// connection_aging_table: top level, command decode, eviction sequencing and result register.
// Depends on cat_pkg and cat_cell.
//
// Usage:
//   Commands enter on i_cmd (func, connection_id) and are taken at a clock edge
//   with start high and busy low. Each command yields one or more result beats on
//   o_result, each shown for exactly one cycle with o_result_valid high; the final
//   beat of a command has last set. The receiver cannot stall; every beat must be
//   taken in the cycle it appears.
//   Insert, delete and the no-op code: the command is decoded in S_EXEC and its
//   beat is then registered onto o_result; the controller returns to idle as the
//   beat is registered, and only then is a new command taken. Tick: S_EXEC ages
//   every slot in parallel, then S_EVICT gives one evicted entry per cycle (or one
//   empty result beat if none expired). Evictions are sequenced by removing the
//   lowest expired slot each cycle and shifting the cells above it down the chain.
//   Timeout is to be written by the user through i_cfg_we / i_cfg_wdata while idle,
//   which the block itself does not enforce; it takes effect on the next tick.
//   Reset (synchronous, active low) empties the table, sets the timeout to 60 and
//   returns the controller to idle.

module connection_aging_table
    import cat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [TIMEOUT_W-1:0]  i_cfg_wdata,
    output logic                  o_result_valid,
    output t_result               o_result
);

    t_state                 r_state, n_state;
    t_func                  r_func;
    logic [ID_WIDTH-1:0]    r_key;
    logic [TIMEOUT_W-1:0]   r_timeout;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;

    t_cell_op               cell_op   [TABLE_DEPTH];
    t_cell_meta             cell_meta [TABLE_DEPTH];
    logic [ID_WIDTH-1:0]    cell_id   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid, w_expire, w_match;
    logic [TABLE_DEPTH-1:0] free_oh, del_mask, ev_mask, ev_oh;
    logic [ID_WIDTH-1:0]    ev_id;
    logic                   ev_single;

    // Row of cells; each takes its upper neighbor's contents on a shift
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        t_cell_meta          nbr_meta;
        logic [ID_WIDTH-1:0] nbr_id;

        if (gi == TABLE_DEPTH - 1) begin : g_top
            assign nbr_meta = '0;
            assign nbr_id   = '0;
        end else begin : g_mid
            assign nbr_meta = cell_meta[gi+1];
            assign nbr_id   = cell_id[gi+1];
        end

        cat_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (cell_op[gi]),
            .i_timeout  (r_timeout),
            .i_key      (r_key),
            .i_nbr_meta (nbr_meta),
            .i_nbr_id   (nbr_id),
            .o_meta     (cell_meta[gi]),
            .o_id       (cell_id[gi]),
            .o_match    (w_match[gi])
        );

        assign w_valid[gi]  = cell_meta[gi].valid;
        assign w_expire[gi] = cell_meta[gi].expire;
    end

    // Slot masks: occupied slots are always packed at the bottom
    assign free_oh   = ~w_valid & ((w_valid << 1) | TABLE_DEPTH'(1));
    assign del_mask  = w_match | (~w_match + TABLE_DEPTH'(1));
    assign ev_mask   = w_expire | (~w_expire + TABLE_DEPTH'(1));
    assign ev_oh     = w_expire & (~w_expire + TABLE_DEPTH'(1));
    assign ev_single = ((w_expire & (w_expire - TABLE_DEPTH'(1))) == '0);

    // Id of the lowest expired slot
    always_comb begin
        ev_id = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (ev_oh[i]) begin
                ev_id = ev_id | cell_id[i];
            end
        end
    end

    // Controller: next state, cell operations and result beat
    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_out       = '{status: ST_OK, evicted_valid: 1'b0, evicted_id: '0, last: 1'b1};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_op[i] = CELL_HOLD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                case (r_func)
                    FUNC_INSERT: begin
                        if (|w_match) begin
                            n_out.status = ST_PRESENT;
                        end else if (&w_valid) begin
                            n_out.status = ST_FULL;
                        end else begin
                            for (int i = 0; i < TABLE_DEPTH; i++) begin
                                if (free_oh[i]) begin
                                    cell_op[i] = CELL_WRITE;
                                end
                            end
                        end
                    end
                    FUNC_DELETE: begin
                        if (|w_match) begin
                            for (int i = 0; i < TABLE_DEPTH; i++) begin
                                if (del_mask[i]) begin
                                    cell_op[i] = CELL_SHIFT;
                                end
                            end
                        end else begin
                            n_out.status = ST_NOT_FOUND;
                        end
                    end
                    FUNC_TICK: begin
                        n_out_valid = 1'b0;
                        n_state     = S_EVICT;
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            cell_op[i] = CELL_AGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EVICT: begin
                n_out_valid = 1'b1;
                if (w_expire == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_out.evicted_valid = 1'b1;
                    n_out.evicted_id    = CMD_ID_W'(ev_id);
                    n_out.last          = ev_single;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (ev_mask[i]) begin
                            cell_op[i] = CELL_SHIFT;
                        end
                    end
                    if (ev_single) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, strobe and timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // Command capture and result payload
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_func <= i_cmd.func;
            r_key  <= ID_WIDTH'(i_cmd.connection_id);
        end
        r_out <= n_out;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef SYNTH
    // Occupied slots stay packed at the bottom of the row
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + TABLE_DEPTH'(1))) == '0)
        else $error("table not compacted");

    // Only occupied slots can be marked expired
    a_expire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_expire & ~w_valid) == '0)
        else $error("expire flag on empty slot");

    // A rise of the result strobe always follows a busy cycle
    a_beat_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> $past(r_state == S_EXEC || r_state == S_EVICT))
        else $error("result beat without a command");

    // The final beat of a command leaves the controller idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |-> (r_state == S_IDLE))
        else $error("final beat while still busy");

    // Only eviction beats can be non-final
    a_nonlast_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.last) |-> o_result.evicted_valid)
        else $error("non-final beat without eviction");

    // No expired slot survives the end of a tick
    a_tick_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT && n_state == S_IDLE) |=> (w_expire == '0))
        else $error("expired slot left after tick");
`endif

endmodule
